// ===== rtl/frame_offset_sse_search_top_assert.svh =====
// Assertion macros shared by the frame offset search RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef FRAME_OFFSET_SSE_SEARCH_TOP_ASSERT_SVH
`define FRAME_OFFSET_SSE_SEARCH_TOP_ASSERT_SVH

// Checked at every rising edge outside reset.
`define FOSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("foss: assertion failed");

// Same, with a message of the caller's choosing.
`define FOSS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ===== rtl/foss_pkg.sv =====
// Types and constants of the frame offset search block.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package foss_pkg;

  localparam int SUM_BITS   = 38;   // width of one error sum
  localparam int DIM_BITS   = 12;   // frame_width / frame_height registers
  localparam int CROP_BITS  = 7;
  localparam int ROW_BITS   = 11;
  localparam int MAX_HEIGHT = 2048;
  localparam int NTAP       = 3;    // shifts per axis
  localparam int IDX_BITS   = 2;

  localparam int OUT_DEPTH  = 8;    // result queue entries
  localparam int PTR_BITS   = $clog2(OUT_DEPTH);
  localparam int PEND_BITS  = $clog2(OUT_DEPTH + 1);

  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BORDER_CROP  = 2'd2;

  localparam logic [DIM_BITS-1:0]  RST_FRAME_WIDTH  = 12'd1920;
  localparam logic [DIM_BITS-1:0]  RST_FRAME_HEIGHT = 12'd1080;
  localparam logic [CROP_BITS-1:0] RST_BORDER_CROP  = 7'd8;

  // Pipeline control for one beat.
  typedef struct packed {
    logic vld;
    logic acc;  // centre inside the cropped area
    logic fe;   // last pixel of the frame
  } stage_ctrl_t;

  // Least sum of one cell and the dy index that gave it.
  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [IDX_BITS-1:0] idx;
  } cell_best_t;

  typedef struct packed {
    logic signed [1:0]   best_dx;
    logic signed [1:0]   best_dy;
    logic [SUM_BITS-1:0] least_error;
  } result_t;

  // Tap index 0..2 to shift -1..1.
  function automatic logic signed [1:0] idx_to_shift(input logic [IDX_BITS-1:0] idx);
    logic signed [1:0] s;
    case (idx)
      2'd0:    s = -2'sd1;
      2'd1:    s = 2'sd0;
      2'd2:    s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/foss_line_buf.sv =====
// Line stores: two lines of processed pixels, one line of reference pixels.
// Builds the incoming window column and the centre reference pixel. Uses foss_pkg.
`timescale 1ns / 1ps

module foss_line_buf #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                col_idx,
  input  logic                                        lane,
  input  logic [PIXEL_BITS-1:0]                       ref_pixel,
  input  logic [PIXEL_BITS-1:0]                       proc_pixel,
  input  logic                                        shift_en,
  output logic [foss_pkg::NTAP-1:0][PIXEL_BITS-1:0]   col,
  output logic [PIXEL_BITS-1:0]                       center
);

  logic [PIXEL_BITS-1:0] proc0_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] proc1_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] ref_mem   [MAX_WIDTH];

  logic [PIXEL_BITS-1:0] rd0_r, rd1_r, rref_r, pp_r, hold_r;
  logic                  lane_r;

  // read-before-write on each store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rd0_r <= proc0_mem[col_idx];
      if (!lane) proc0_mem[col_idx] <= proc_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rd1_r <= proc1_mem[col_idx];
      if (lane) proc1_mem[col_idx] <= proc_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rref_r            <= ref_mem[col_idx];
      ref_mem[col_idx]  <= ref_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pp_r   <= proc_pixel;
      lane_r <= lane;
    end
  end

  // one-pixel hold: reference one pixel behind on the row above
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (shift_en) begin
      hold_r <= rref_r;
    end
  end

  // rows r-2, r-1, r
  assign col[0] = lane_r ? rd1_r : rd0_r;
  assign col[1] = lane_r ? rd0_r : rd1_r;
  assign col[2] = pp_r;
  assign center = hold_r;

endmodule

// ===== rtl/foss_cell.sv =====
// One window column (one dx): three pixels, three squared-error sums, argmin over dy.
// Column passes to the left neighbour each beat. Uses foss_pkg.
`timescale 1ns / 1ps

module foss_cell #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       shift_en,
  input  logic [PIXEL_BITS-1:0]                      center,
  input  logic [foss_pkg::NTAP-1:0][PIXEL_BITS-1:0]  col_in,
  output logic [foss_pkg::NTAP-1:0][PIXEL_BITS-1:0]  col_out,
  input  foss_pkg::stage_ctrl_t                      s2,
  input  logic                                       s3_vld,
  output foss_pkg::cell_best_t                       best
);

  localparam int SQ_BITS = 2 * PIXEL_BITS;
  localparam int NT      = foss_pkg::NTAP;
  localparam int SB      = foss_pkg::SUM_BITS;

  logic [NT-1:0][PIXEL_BITS-1:0] col_r;
  logic [NT-1:0][SQ_BITS-1:0]    sq_r, sq_nxt;
  logic [NT-1:0][SB-1:0]         sum_r, sum_nxt, snap_r;

  logic signed [PIXEL_BITS:0]     diff [NT];
  logic signed [2*PIXEL_BITS+1:0] prod [NT];
  logic [SB:0]                    acc_ext [NT];

  foss_pkg::cell_best_t best_r, best_nxt;

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      diff[k]    = $signed({1'b0, center}) - $signed({1'b0, col_in[k]});
      prod[k]    = diff[k] * diff[k];
      sq_nxt[k]  = prod[k][SQ_BITS-1:0];
      acc_ext[k] = {1'b0, sum_r[k]} + (SB + 1)'(sq_r[k]);
      if (s2.acc) begin
        sum_nxt[k] = acc_ext[k][SB] ? {SB{1'b1}} : acc_ext[k][SB-1:0];
      end else begin
        sum_nxt[k] = sum_r[k];
      end
    end
  end

  // earliest dy wins a tie
  always_comb begin
    best_nxt.sum = snap_r[0];
    best_nxt.idx = 2'd0;
    if (snap_r[1] < best_nxt.sum) begin
      best_nxt.sum = snap_r[1];
      best_nxt.idx = 2'd1;
    end
    if (snap_r[2] < best_nxt.sum) begin
      best_nxt.sum = snap_r[2];
      best_nxt.idx = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      sum_r <= '0;
    end else begin
      if (shift_en) col_r <= col_in;
      if (s2.vld)   sum_r <= s2.fe ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en)          sq_r   <= sq_nxt;
    if (s2.vld && s2.fe)   snap_r <= sum_nxt;
    if (s3_vld)            best_r <= best_nxt;
  end

  assign col_out = col_r;
  assign best    = best_r;

endmodule

// ===== rtl/foss_out_fifo.sv =====
// Result queue between the search pipeline and the out channel.
// Register array, OUT_DEPTH entries. Uses foss_pkg and the assertion header.
`timescale 1ns / 1ps

`include "frame_offset_sse_search_top_assert.svh"

module foss_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  foss_pkg::result_t push_data,
  output logic              out_valid,
  input  logic              out_ready,
  output foss_pkg::result_t head
);

  foss_pkg::result_t                  fifo_r [foss_pkg::OUT_DEPTH];
  logic [foss_pkg::PTR_BITS-1:0]      wr_ptr_r, rd_ptr_r;
  logic [foss_pkg::PEND_BITS-1:0]     cnt_r, cnt_nxt;
  logic                               pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = fifo_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= push_data;
  end

  `FOSS_ASSERT_MSG(a_no_push_full, push |-> (cnt_r != foss_pkg::PEND_BITS'(foss_pkg::OUT_DEPTH)), "foss: result queue overrun")
  `FOSS_ASSERT(a_cnt_bound, cnt_r <= foss_pkg::PEND_BITS'(foss_pkg::OUT_DEPTH))
  `FOSS_ASSERT(a_head_stable, (out_valid && !out_ready) |=> (out_valid && $stable(head)))

endmodule

// ===== rtl/frame_offset_sse_search_top.sv =====
// Top level of the frame offset search: config registers, raster counters, pipeline.
// Instantiates foss_line_buf, foss_cell (x3), foss_out_fifo; uses foss_pkg and the assertion header.
`timescale 1ns / 1ps

`include "frame_offset_sse_search_top_assert.svh"

// Usage
//  in channel : one beat = one co-located pixel pair (reference, processed), raster
//               order. One beat per cycle sustained while in_ready is high.
//  out channel: one beat per frame, at the last pixel: best (dx, dy) in -1..1 and its
//               sum of squared differences. Ties go to the earliest shift, dx outer.
//  APB port   : frame_width @0x0, frame_height @0x4, border_crop @0x8. Write only
//               while idle; values take effect from the next pixel.
//  Pipeline   : memory read at the last pixel's accepting edge, then square,
//               accumulate, per-column argmin, column argmin into the queue;
//               out_valid rises once the result is queued.
//  Throughput : 1 pixel per cycle while in_ready is high. The pipeline never stalls;
//               results land in an 8-entry queue. in_ready drops only for a frame-ending
//               pixel while 8 results are already queued or in flight, so a stalled
//               receiver holds off at most the pixel that would close a ninth frame.
//  Reset      : rst_n synchronous; registers go to 1920 x 1080, crop 8, counters,
//               window and sums to zero, queue empty. Line stores are not cleared
//               and fill during the first two lines.

module frame_offset_sse_search_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input pixels
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [PIXEL_BITS-1:0]                in_ref_pixel,
  input  logic [PIXEL_BITS-1:0]                in_proc_pixel,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [1:0]                    out_best_dx,
  output logic signed [1:0]                    out_best_dy,
  output logic [foss_pkg::SUM_BITS-1:0]        out_least_error,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [foss_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [foss_pkg::DATA_BITS-1:0]       pwdata,
  output logic [foss_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  // compare width: covers the 12-bit registers and MAX_WIDTH itself
  localparam int WB = (CW + 1 > foss_pkg::DIM_BITS) ? CW + 1 : foss_pkg::DIM_BITS;
  localparam int AB = WB + 1;
  localparam int NT = foss_pkg::NTAP;

  // ---------------------------------------------------------------- config
  logic [foss_pkg::DIM_BITS-1:0]  cfg_width_r, cfg_height_r;
  logic [foss_pkg::CROP_BITS-1:0] cfg_crop_r;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= foss_pkg::RST_FRAME_WIDTH;
      cfg_height_r <= foss_pkg::RST_FRAME_HEIGHT;
      cfg_crop_r   <= foss_pkg::RST_BORDER_CROP;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        foss_pkg::REG_FRAME_WIDTH:  cfg_width_r  <= pwdata[foss_pkg::DIM_BITS-1:0];
        foss_pkg::REG_FRAME_HEIGHT: cfg_height_r <= pwdata[foss_pkg::DIM_BITS-1:0];
        foss_pkg::REG_BORDER_CROP:  cfg_crop_r   <= pwdata[foss_pkg::CROP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      foss_pkg::REG_FRAME_WIDTH:  prdata = foss_pkg::DATA_BITS'(cfg_width_r);
      foss_pkg::REG_FRAME_HEIGHT: prdata = foss_pkg::DATA_BITS'(cfg_height_r);
      foss_pkg::REG_BORDER_CROP:  prdata = foss_pkg::DATA_BITS'(cfg_crop_r);
      default:                    prdata = '0;
    endcase
  end

  // effective geometry: width 1..MAX_WIDTH, height 1..2048, crop >= 1
  logic [AB-1:0] w_eff, h_eff, crop_eff;

  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = AB'(1);
    end else if (AB'(cfg_width_r) > AB'(MAX_WIDTH)) begin
      w_eff = AB'(MAX_WIDTH);
    end else begin
      w_eff = AB'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = AB'(1);
    end else if (AB'(cfg_height_r) > AB'(foss_pkg::MAX_HEIGHT)) begin
      h_eff = AB'(foss_pkg::MAX_HEIGHT);
    end else begin
      h_eff = AB'(cfg_height_r);
    end
    crop_eff = (cfg_crop_r == '0) ? AB'(1) : AB'(cfg_crop_r);
  end

  // ---------------------------------------------------------------- raster position
  logic [CW-1:0]                col_r;
  logic [foss_pkg::ROW_BITS-1:0] row_r;
  logic [AB-1:0]                rr, cc;
  logic                         line_end, frame_end, in_area, accept;

  // centre pixel sits one row up and one column left of the arriving one
  assign rr        = AB'(row_r) - AB'(1);
  assign cc        = AB'(col_r) - AB'(1);
  assign line_end  = (AB'(col_r) + AB'(1)) >= w_eff;
  assign frame_end = line_end && ((AB'(row_r) + AB'(1)) >= h_eff);
  assign in_area   = (row_r != '0) && (col_r != '0) &&
                     (rr >= crop_eff) && ((rr + crop_eff) < h_eff) &&
                     (cc >= crop_eff) && ((cc + crop_eff) < w_eff);

  // results owed to the out side: queued plus in flight
  logic [foss_pkg::PEND_BITS-1:0] pend_r;
  logic                           out_pop;

  assign in_ready = !(frame_end && (pend_r == foss_pkg::PEND_BITS'(foss_pkg::OUT_DEPTH)));
  assign accept   = in_valid && in_ready;
  assign out_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      if (accept) begin
        if (line_end) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      pend_r <= pend_r + (foss_pkg::PEND_BITS'(accept && frame_end))
                       - (foss_pkg::PEND_BITS'(out_pop));
    end
  end

  // ---------------------------------------------------------------- pipeline control
  foss_pkg::stage_ctrl_t s1_r, s2_r;
  logic                  s3_vld_r, s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r     <= '0;
      s2_r     <= '0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_r.vld <= accept;
      s1_r.acc <= accept && in_area;
      s1_r.fe  <= accept && frame_end;
      s2_r     <= s1_r;
      s3_vld_r <= s2_r.vld && s2_r.fe;
      s4_vld_r <= s3_vld_r;
    end
  end

  // ---------------------------------------------------------------- line stores
  logic [NT-1:0][PIXEL_BITS-1:0] new_col;
  logic [PIXEL_BITS-1:0]         center;

  foss_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (accept),
    .col_idx    (col_r),
    .lane       (row_r[0]),
    .ref_pixel  (in_ref_pixel),
    .proc_pixel (in_proc_pixel),
    .shift_en   (s1_r.vld),
    .col        (new_col),
    .center     (center)
  );

  // ---------------------------------------------------------------- cell chain
  // cell 2 (dx = +1) takes the new column, hands it on to cell 1, then cell 0
  logic [NT-1:0][PIXEL_BITS-1:0] chain_col [1:NT];
  foss_pkg::cell_best_t          cell_best [NT];

  assign chain_col[NT] = new_col;

  for (genvar k = 0; k < NT; k++) begin : g_cell
    if (k == 0) begin : g_end
      foss_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_r.vld),
        .center   (center),
        .col_in   (chain_col[k+1]),
        .col_out  (),
        .s2       (s2_r),
        .s3_vld   (s3_vld_r),
        .best     (cell_best[k])
      );
    end else begin : g_mid
      foss_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_r.vld),
        .center   (center),
        .col_in   (chain_col[k+1]),
        .col_out  (chain_col[k]),
        .s2       (s2_r),
        .s3_vld   (s3_vld_r),
        .best     (cell_best[k])
      );
    end
  end

  // ---------------------------------------------------------------- final argmin over dx
  foss_pkg::cell_best_t       win;
  logic [foss_pkg::IDX_BITS-1:0] win_dx;
  foss_pkg::result_t          res;

  always_comb begin
    win    = cell_best[0];
    win_dx = 2'd0;
    if (cell_best[1].sum < win.sum) begin
      win    = cell_best[1];
      win_dx = 2'd1;
    end
    if (cell_best[2].sum < win.sum) begin
      win    = cell_best[2];
      win_dx = 2'd2;
    end
    res.best_dx     = foss_pkg::idx_to_shift(win_dx);
    res.best_dy     = foss_pkg::idx_to_shift(win.idx);
    res.least_error = win.sum;
  end

  // ---------------------------------------------------------------- result queue
  foss_pkg::result_t head;

  foss_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s4_vld_r),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_best_dx     = head.best_dx;
  assign out_best_dy     = head.best_dy;
  assign out_least_error = head.least_error;

  // ---------------------------------------------------------------- checks
  `FOSS_ASSERT(a_pend_bound, pend_r <= foss_pkg::PEND_BITS'(foss_pkg::OUT_DEPTH))
  `FOSS_ASSERT(a_out_owed, out_valid |-> (pend_r != '0))
  `FOSS_ASSERT_MSG(a_push_from_frame_end, s4_vld_r |-> $past(accept && frame_end, 4), "foss: result without frame end")

endmodule

// ===== dv/foss_shift_checker.sv =====
// Scoreboard for the frame offset search: predicts each frame's best shift and checks result beats.
// Depends on foss_pkg; watches the pixel, result and APB channels of frame_offset_sse_search_top.
`timescale 1ns / 1ps

module foss_shift_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_ref_pixel,
  input  logic [7:0]                     in_proc_pixel,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [1:0]              out_best_dx,
  input  logic signed [1:0]              out_best_dy,
  input  logic [foss_pkg::SUM_BITS-1:0]  out_least_error,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [foss_pkg::ADDR_BITS-1:0] paddr,
  input  logic [foss_pkg::DATA_BITS-1:0] pwdata,
  output int unsigned                    mismatches,
  output int unsigned                    results_due
);

  localparam int LINE_MAX = 2048;
  localparam logic [foss_pkg::SUM_BITS-1:0] SUM_SAT = '1;

  logic [foss_pkg::DIM_BITS-1:0]  width_reg;
  logic [foss_pkg::DIM_BITS-1:0]  height_reg;
  logic [foss_pkg::CROP_BITS-1:0] crop_reg;

  logic [7:0]                    proc_lines [2][LINE_MAX];
  logic [7:0]                    ref_line [LINE_MAX];
  logic [7:0]                    ref_hold;
  // [row r-2..r][column c-2..c]
  logic [7:0]                    win [foss_pkg::NTAP][foss_pkg::NTAP];
  // [dx][dy]
  logic [foss_pkg::SUM_BITS-1:0] shift_sse [foss_pkg::NTAP][foss_pkg::NTAP];
  int unsigned                   col;
  int unsigned                   row;

  foss_pkg::result_t expected_shifts [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t foss: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic clear_sums();
    int i;
    int j;
    for (i = 0; i < foss_pkg::NTAP; i++)
      for (j = 0; j < foss_pkg::NTAP; j++) shift_sse[i][j] = '0;
  endtask

  task automatic clear_state();
    int i;
    int j;
    width_reg  = foss_pkg::RST_FRAME_WIDTH;
    height_reg = foss_pkg::RST_FRAME_HEIGHT;
    crop_reg   = foss_pkg::RST_BORDER_CROP;
    for (i = 0; i < LINE_MAX; i++) begin
      proc_lines[0][i] = '0;
      proc_lines[1][i] = '0;
      ref_line[i]      = '0;
    end
    for (i = 0; i < foss_pkg::NTAP; i++)
      for (j = 0; j < foss_pkg::NTAP; j++) win[i][j] = '0;
    clear_sums();
    ref_hold = '0;
    col      = 0;
    row      = 0;
    expected_shifts.delete();
  endtask

  // earliest least sum, dx outer
  function automatic foss_pkg::result_t pick_least();
    foss_pkg::result_t             pick;
    logic [foss_pkg::SUM_BITS-1:0] best;
    int                            bx;
    int                            by;
    int                            i;
    int                            j;
    best = shift_sse[0][0];
    bx   = 0;
    by   = 0;
    for (i = 0; i < foss_pkg::NTAP; i++)
      for (j = 0; j < foss_pkg::NTAP; j++)
        if (shift_sse[i][j] < best) begin
          best = shift_sse[i][j];
          bx   = i;
          by   = j;
        end
    pick.best_dx     = 2'(bx - 1);
    pick.best_dy     = 2'(by - 1);
    pick.least_error = best;
    return pick;
  endfunction

  task automatic advance_shift_sums(input logic [7:0] rp, input logic [7:0] pp);
    int unsigned w;
    int unsigned h;
    int unsigned crop;
    int unsigned ci;
    int unsigned lane;
    int unsigned rr;
    int unsigned cc;
    int          i;
    int          j;
    logic [7:0]  centre;
    logic [7:0]  old_ref;
    longint      diff;
    longint      acc;

    w = width_reg;
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > foss_pkg::MAX_HEIGHT) h = foss_pkg::MAX_HEIGHT;
    crop = crop_reg;
    if (crop < 1) crop = 1;

    ci   = (col < LINE_MAX) ? col : LINE_MAX - 1;
    lane = row & 1;

    for (i = 0; i < foss_pkg::NTAP; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = proc_lines[lane][ci];
    win[1][2] = proc_lines[lane ^ 1][ci];
    win[2][2] = pp;
    proc_lines[lane][ci] = pp;

    // centre lags one line and one pixel behind the arriving position
    old_ref      = ref_line[ci];
    ref_line[ci] = rp;
    centre       = ref_hold;
    ref_hold     = old_ref;

    if (row >= 1 && col >= 1) begin
      rr = row - 1;
      cc = col - 1;
      if (rr >= crop && rr + crop < h && cc >= crop && cc + crop < w) begin
        for (i = 0; i < foss_pkg::NTAP; i++)
          for (j = 0; j < foss_pkg::NTAP; j++) begin
            diff = longint'(centre) - longint'(win[j][i]);
            acc  = longint'(shift_sse[i][j]) + diff * diff;
            shift_sse[i][j] = (acc > longint'(SUM_SAT)) ? SUM_SAT :
                              acc[foss_pkg::SUM_BITS-1:0];
          end
      end
    end

    if (col + 1 >= w) begin
      col = 0;
      if (row + 1 >= h) begin
        row = 0;
        expected_shifts.push_back(pick_least());
        clear_sums();
      end else begin
        row = row + 1;
      end
    end else begin
      col = col + 1;
    end
  endtask

  task automatic check_result();
    foss_pkg::result_t want;
    if (expected_shifts.size() == 0) begin
      report_mismatch("result beat with nothing pending, least_error",
                      longint'(out_least_error), 0);
    end else begin
      want = expected_shifts.pop_front();
      if (out_best_dx !== want.best_dx)
        report_mismatch("best_dx", longint'(out_best_dx), longint'(want.best_dx));
      if (out_best_dy !== want.best_dy)
        report_mismatch("best_dy", longint'(out_best_dy), longint'(want.best_dy));
      if (out_least_error !== want.least_error)
        report_mismatch("least_error", longint'(out_least_error), longint'(want.least_error));
    end
  endtask

  task automatic apply_write(input logic [foss_pkg::ADDR_BITS-1:0] addr,
                             input logic [foss_pkg::DATA_BITS-1:0] data);
    case (addr[3:2])
      foss_pkg::REG_FRAME_WIDTH:  width_reg  = data[foss_pkg::DIM_BITS-1:0];
      foss_pkg::REG_FRAME_HEIGHT: height_reg = data[foss_pkg::DIM_BITS-1:0];
      foss_pkg::REG_BORDER_CROP:  crop_reg   = data[foss_pkg::CROP_BITS-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) advance_shift_sums(in_ref_pixel, in_proc_pixel);
      if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
    end
    results_due = expected_shifts.size();
  end

endmodule

// ===== dv/frame_offset_sse_search_top_test.sv =====
// Testbench top for the frame offset search: clock, reset, pixel/APB stimulus and the verdict.
// Depends on foss_pkg, frame_offset_sse_search_top and foss_shift_checker.
`timescale 1ns / 1ps

module frame_offset_sse_search_top_test;

  localparam int LINE_MAX        = 2048;
  localparam int SETTLE_CYCLES   = 12;     // covers the pipeline latency, with margin on top
  localparam int HOLD_OFF_CYCLES = 80;     // long enough to fill the 8-entry result queue
  localparam int RANDOM_BEATS    = 1800;
  localparam int RANDOM_FRAMES   = 40;

  // Frame contents. The shifted kinds make one shift (or a row/column of shifts) an
  // exact match, so the search has a clear answer; the flat rows/columns force ties.
  typedef enum int {
    PAT_SHIFTED,
    PAT_ROW_FLAT,    // every line constant: dx cannot be told apart
    PAT_COL_FLAT,    // every column constant: dy cannot be told apart
    PAT_NOISE,
    PAT_FLAT,        // one level everywhere: all sums zero
    PAT_EXTREME      // reference and processed at opposite rails: every squared difference at maximum
  } frame_pattern_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [7:0]                     in_ref_pixel;
  logic [7:0]                     in_proc_pixel;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [1:0]              out_best_dx;
  logic signed [1:0]              out_best_dy;
  logic [foss_pkg::SUM_BITS-1:0]  out_least_error;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [foss_pkg::ADDR_BITS-1:0] paddr;
  logic [foss_pkg::DATA_BITS-1:0] pwdata;
  logic [foss_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  int unsigned mismatches;
  int unsigned results_due;

  // stimulus knobs, shared with the receiver process
  bit tx_gaps_on;
  bit rx_gaps_on;
  bit hold_req;

  // effective frame size as the block sees it after clamping
  int cur_w;
  int cur_h;

  frame_offset_sse_search_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ref_pixel   (in_ref_pixel),
    .in_proc_pixel  (in_proc_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_dx    (out_best_dx),
    .out_best_dy    (out_best_dy),
    .out_least_error(out_least_error),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  foss_shift_checker u_shift_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ref_pixel   (in_ref_pixel),
    .in_proc_pixel  (in_proc_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_dx    (out_best_dx),
    .out_best_dy    (out_best_dy),
    .out_least_error(out_least_error),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
  endfunction

  function automatic int eff_dim(input int unsigned v);
    return (v < 1) ? 1 : ((v > LINE_MAX) ? LINE_MAX : int'(v));
  endfunction

  function automatic int clamp_index(input int v, input int lim);
    return (v < 0) ? 0 : ((v >= lim) ? lim - 1 : v);
  endfunction

  // Register value with random junk above the field, which the block must drop.
  function automatic logic [foss_pkg::DATA_BITS-1:0] with_junk(input int unsigned v,
                                                               input int bits);
    logic [foss_pkg::DATA_BITS-1:0] junk;
    junk = $urandom_range(0, 1) ? ($urandom() << bits) : '0;
    return junk | foss_pkg::DATA_BITS'(v);
  endfunction

  function automatic frame_pattern_t pick_pattern();
    int unsigned roll;
    roll = $urandom_range(0, 11);
    if (roll < 6)   return PAT_SHIFTED;
    if (roll == 6)  return PAT_ROW_FLAT;
    if (roll == 7)  return PAT_COL_FLAT;
    if (roll < 10)  return PAT_NOISE;
    if (roll == 10) return PAT_FLAT;
    return PAT_EXTREME;
  endfunction

  // ------------------------------------------------------------------------
  // Receiver: random ready gaps when enabled; a hold-off request drops ready
  // for a long fixed stretch so the result queue fills and in_ready falls.
  // ------------------------------------------------------------------------
  initial begin
    int unsigned rest;
    rest      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (rest != 0) begin
        rest--;
        out_ready <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
        rest = idle_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One pixel beat. Entered just after an edge; returns at the accepting rising edge.
  // valid stays high between back-to-back beats, so it is only lowered for a gap.
  task automatic send_pixel(input logic [7:0] rp, input logic [7:0] pp);
    int unsigned gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_ref_pixel  <= rp;
    in_proc_pixel <= pp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering, wait for every pending result, then let the pipeline empty out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup, then access until pready. Entered and left at a falling edge;
  // it idles with psel low before returning, so back-to-back writes never collide in one step.
  task automatic write_reg(input logic [1:0] idx,
                           input logic [foss_pkg::DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_frame(input int unsigned w, input int unsigned h, input int unsigned crop);
    write_reg(foss_pkg::REG_FRAME_WIDTH,  with_junk(w & 12'hFFF, foss_pkg::DIM_BITS));
    write_reg(foss_pkg::REG_FRAME_HEIGHT, with_junk(h & 12'hFFF, foss_pkg::DIM_BITS));
    write_reg(foss_pkg::REG_BORDER_CROP,  with_junk(crop & 7'h7F, foss_pkg::CROP_BITS));
    cur_w = eff_dim(w & 12'hFFF);
    cur_h = eff_dim(h & 12'hFFF);
  endtask

  // Builds one frame of the current size and streams it in raster order.
  task automatic send_frame(input frame_pattern_t pat);
    logic [7:0] proc_img [];
    logic [7:0] ref_img [];
    logic [7:0] level;
    int         sx;
    int         sy;
    int         r;
    int         c;
    int         k;
    int         n;

    n        = cur_w * cur_h;
    proc_img = new[n];
    ref_img  = new[n];
    sx       = int'($urandom_range(0, 2)) - 1;
    sy       = int'($urandom_range(0, 2)) - 1;
    level    = 8'($urandom);

    for (r = 0; r < cur_h; r++)
      for (c = 0; c < cur_w; c++) begin
        k = r * cur_w + c;
        case (pat)
          PAT_FLAT: begin
            proc_img[k] = level;
            ref_img[k]  = level;
          end
          PAT_EXTREME: begin
            proc_img[k] = level[7] ? 8'hFF : 8'h00;
            ref_img[k]  = ~proc_img[k];
          end
          PAT_NOISE: begin
            proc_img[k] = 8'($urandom);
            ref_img[k]  = 8'($urandom);
          end
          PAT_ROW_FLAT: proc_img[k] = (c > 0) ? proc_img[k - 1] : 8'($urandom);
          PAT_COL_FLAT: proc_img[k] = (r > 0) ? proc_img[k - cur_w] : 8'($urandom);
          default:      proc_img[k] = 8'($urandom);
        endcase
      end

    // Shifted kinds: reference at (r, c) is the processed pixel at (r+sy, c+sx),
    // so that shift sums to zero inside the crop. Sometimes a few pixels get spoilt.
    if (pat == PAT_SHIFTED || pat == PAT_ROW_FLAT || pat == PAT_COL_FLAT) begin
      for (r = 0; r < cur_h; r++)
        for (c = 0; c < cur_w; c++)
          ref_img[r * cur_w + c] =
            proc_img[clamp_index(r + sy, cur_h) * cur_w + clamp_index(c + sx, cur_w)];
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) ref_img[$urandom_range(0, n - 1)] = 8'($urandom);
    end

    for (k = 0; k < n; k++) send_pixel(ref_img[k], proc_img[k]);
  endtask

  // ------------------------------------------------------------------------
  // Main stimulus
  // ------------------------------------------------------------------------
  initial begin
    int unsigned random_beats;
    int unsigned frames_sent;
    int unsigned nframes;
    int unsigned roll;
    int unsigned w;
    int unsigned h;
    int unsigned crop;
    int unsigned f;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_ref_pixel  = '0;
    in_proc_pixel = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_gaps_on    = 1'b0;
    rx_gaps_on    = 1'b0;
    hold_req      = 1'b0;
    random_beats  = 0;
    frames_sent   = 0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // Zero width/height/crop: clamps to one-pixel frames with crop one, so the inset
    // is empty and every pixel closes a frame with the (-1,-1) zero answer.
    program_frame(0, 0, 0);
    send_pixel(8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00);
    settle();

    // Smallest frame with a non-empty inset: a single centre pixel.
    program_frame(3, 3, 1);
    send_frame(PAT_SHIFTED);
    send_frame(PAT_EXTREME);
    settle();

    // Crop far larger than the frame: empty inset.
    program_frame(3, 3, 127);
    send_frame(PAT_NOISE);
    settle();

    // --- receiver back-pressure ---
    // One-pixel frames, sender flat out, receiver held off: the queue fills and
    // in_ready has to drop until the receiver comes back.
    program_frame(1, 1, 1);
    hold_req = 1'b1;
    repeat (30) send_pixel(8'($urandom), 8'($urandom));
    settle();

    // --- random phases ---
    // Each phase picks a small frame size, now and then a zero one that clamps,
    // and runs a few frames of it, so the beats land in many short frames.
    while (random_beats < RANDOM_BEATS || frames_sent < RANDOM_FRAMES) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      nframes    = $urandom_range(1, 4);
      roll  = $urandom_range(0, 11);
      w     = (roll == 0) ? $urandom_range(0, 2) :
              (roll == 1) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      roll  = $urandom_range(0, 11);
      h     = (roll == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      roll  = $urandom_range(0, 20);
      crop  = (roll < 16) ? 1 : (roll < 19) ? 2 : (roll == 19) ? 0 :
              $urandom_range(3, 127);
      program_frame(w, h, crop);
      if ($urandom_range(0, 9) == 0) hold_req = 1'b1;

      for (f = 0; f < nframes; f++) begin
        send_frame(pick_pattern());
        frames_sent++;
        random_beats += cur_w * cur_h;
        // sender sometimes pauses until every result is in, without touching config
        if ($urandom_range(0, 4) == 0) settle();
      end
      settle();
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: about 2k beats at a long gap each, plus hold-offs and settles, stays
  // well inside 10 ms.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/foss_pkg.sv
rtl/foss_line_buf.sv
rtl/foss_cell.sv
rtl/foss_out_fifo.sv
rtl/frame_offset_sse_search_top.sv
dv/foss_shift_checker.sv
dv/frame_offset_sse_search_top_test.sv
